FILE: rtl/core/led_icon_blink_and_chase_top_assert.svh
// Assertion macros shared by the icon blink and chase modules.
`ifndef LED_ICON_BLINK_AND_CHASE_TOP_ASSERT_SVH
`define LED_ICON_BLINK_AND_CHASE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define LBC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbc assertion failed");
// next-cycle implication
`define LBC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbc assertion failed");
`else
`define LBC_ASSERT_IMP(lbl, ante, cons)
`define LBC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/lbc_pkg.sv
// Shared types and constants of the icon LED blink and chase block.
package lbc_pkg;

	localparam int ICON_SLOTS  = 8;
	localparam int ICON_W      = 3;
	localparam int CNT_W       = 4;
	localparam int ITEM_IDX_W  = 8;
	localparam int COLOR_W     = 24;
	localparam int CHAN_W      = 8;
	localparam int PERIOD_W    = 16;
	localparam int TIME_W      = 32;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(ICON_SLOTS);
	localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
	localparam logic [ICON_W-1:0] ICON_ONE = ICON_W'(1);

	// item kinds
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ICON_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_COLOR    = 2'd2;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE         = 3'd0,
		OP_ACCEPT       = 3'd1,
		OP_DECODE       = 3'd2,
		OP_SCAN         = 3'd3,
		OP_CHASE_FIRST  = 3'd4,
		OP_CHASE_SECOND = 3'd5,
		OP_CMD          = 3'd6,
		OP_FLUSH        = 3'd7
	} op_t;

	typedef struct packed {
		op_t  op;
		logic cfg_open;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic cnt_zero;
		logic cmd_in_range;
		logic scan_hit;
		logic scan_last;
		logic chase_due;
		logic chase_two;
		logic produce_ok;
		logic flush_ok;
		logic hold_valid;
	} dp_status_t;

endpackage

FILE: rtl/core/led_icon_blink_and_chase_top.sv
// A command's result enters the hold slot in the command state, the output register on release.
// Throughput: one request per pass; a command pass runs accept, decode, command and release,
// a tick pass accept, decode, one scan step per icon, chase, a second chase step when it
// writes two icons, and release; a tick with no icons or a dropped command stops after decode.
// Any pass stretches while a result waits on a stalled output register.
// Reset: arst_n clears config, time, chase, blink flags and result stages; blink data undefined.
module led_icon_blink_and_chase_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// requests
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [lbc_pkg::MODE_W-1:0]            mode,
	input  logic [lbc_pkg::ITEM_IDX_W-1:0]        icon_index,
	input  logic [lbc_pkg::CHAN_W-1:0]            red,
	input  logic [lbc_pkg::CHAN_W-1:0]            green,
	input  logic [lbc_pkg::CHAN_W-1:0]            blue,
	input  logic [lbc_pkg::PERIOD_W-1:0]          blink_period,
	// register writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lbc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lbc_pkg::CFG_DATA_W-1:0]        cfg_data,
	// results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  pixel_write,
	output logic [lbc_pkg::ICON_W-1:0]            pixel_index,
	output logic [lbc_pkg::COLOR_W-1:0]           pixel_color,
	output logic                                  refresh,
	output logic                                  last
);

	lbc_pkg::ctrl_cmd_t  cmd;
	lbc_pkg::dp_status_t status;

	assign cfg_ready = cmd.cfg_open;

	// sequencer
	lbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// state, blink store and result stages
	lbc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.mode         (mode),
		.icon_index   (icon_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.blink_period (blink_period),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_write  (pixel_write),
		.pixel_index  (pixel_index),
		.pixel_color  (pixel_color),
		.refresh      (refresh),
		.last         (last)
	);

endmodule

FILE: rtl/core/lbc_ctrl.sv
// Controller state machine of the icon LED blink and chase block.
`include "led_icon_blink_and_chase_top_assert.svh"
module lbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lbc_pkg::dp_status_t status,
	output lbc_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_DECODE  = 7'b0000010,
		ST_SCAN    = 7'b0000100,
		ST_CHASE_A = 7'b0001000,
		ST_CHASE_B = 7'b0010000,
		ST_CMD     = 7'b0100000,
		ST_FLUSH   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// one request at a time: take a new one only when idle
	assign in_stall = (state_q != ST_IDLE);

	// next state and datapath operation
	always_comb begin
		state_d      = state_q;
		cmd.op       = lbc_pkg::OP_NONE;
		cmd.cfg_open = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.cfg_open = 1'b1;
				if (in_valid) begin
					cmd.op  = lbc_pkg::OP_ACCEPT;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.op = lbc_pkg::OP_DECODE;
				if (status.is_tick) begin
					state_d = status.cnt_zero ? ST_IDLE : ST_SCAN;
				end else begin
					state_d = status.cmd_in_range ? ST_CMD : ST_IDLE;
				end
			end
			ST_SCAN: begin
				// one icon per cycle; wait when a toggle has no room
				if (!status.scan_hit || status.produce_ok) begin
					cmd.op = lbc_pkg::OP_SCAN;
					if (status.scan_last) begin
						state_d = ST_CHASE_A;
					end
				end
			end
			ST_CHASE_A: begin
				if (!status.chase_due) begin
					state_d = ST_FLUSH;
				end else if (status.produce_ok) begin
					cmd.op  = lbc_pkg::OP_CHASE_FIRST;
					state_d = status.chase_two ? ST_CHASE_B : ST_FLUSH;
				end
			end
			ST_CHASE_B: begin
				if (status.produce_ok) begin
					cmd.op  = lbc_pkg::OP_CHASE_SECOND;
					state_d = ST_FLUSH;
				end
			end
			ST_CMD: begin
				if (status.produce_ok) begin
					cmd.op  = lbc_pkg::OP_CMD;
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!status.hold_valid) begin
					state_d = ST_IDLE;
				end else if (status.flush_ok) begin
					cmd.op  = lbc_pkg::OP_FLUSH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`LBC_ASSERT_NXT(a_accept_decode, (in_valid && !in_stall), (state_q == ST_DECODE))
	`LBC_ASSERT_NXT(a_scan_waits, (state_q == ST_SCAN && status.scan_hit && !status.produce_ok), (state_q == ST_SCAN))
	`LBC_ASSERT_NXT(a_flush_done, (state_q == ST_FLUSH && status.hold_valid && status.flush_ok), (state_q == ST_IDLE && !status.hold_valid))

endmodule

FILE: rtl/core/lbc_datapath.sv
// Datapath of the icon LED blink and chase block: config, time, blink store, result stages.
`include "led_icon_blink_and_chase_top_assert.svh"
module lbc_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lbc_pkg::ctrl_cmd_t                    cmd,
	output lbc_pkg::dp_status_t                   status,
	// request fields
	input  logic [lbc_pkg::MODE_W-1:0]            mode,
	input  logic [lbc_pkg::ITEM_IDX_W-1:0]        icon_index,
	input  logic [lbc_pkg::CHAN_W-1:0]            red,
	input  logic [lbc_pkg::CHAN_W-1:0]            green,
	input  logic [lbc_pkg::CHAN_W-1:0]            blue,
	input  logic [lbc_pkg::PERIOD_W-1:0]          blink_period,
	// register writes
	input  logic                                  cfg_valid,
	input  logic [lbc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lbc_pkg::CFG_DATA_W-1:0]        cfg_data,
	// results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  pixel_write,
	output logic [lbc_pkg::ICON_W-1:0]            pixel_index,
	output logic [lbc_pkg::COLOR_W-1:0]           pixel_color,
	output logic                                  refresh,
	output logic                                  last
);

	localparam int TW = lbc_pkg::TIME_W;
	localparam int NI = lbc_pkg::ICON_SLOTS;

	// configuration
	logic [lbc_pkg::CNT_W-1:0]    icon_count_q;
	logic [lbc_pkg::PERIOD_W-1:0] cycle_interval_q;
	logic [lbc_pkg::COLOR_W-1:0]  cycle_color_q;

	// latched request
	logic [lbc_pkg::MODE_W-1:0]     mode_q;
	logic [lbc_pkg::ITEM_IDX_W-1:0] idx_q;
	logic [lbc_pkg::COLOR_W-1:0]    color_q;
	logic [lbc_pkg::PERIOD_W-1:0]   period_q;

	// time and chase state
	logic [TW-1:0]                time_q;
	logic [TW-1:0]                last_chase_q;
	logic                         chase_valid_q;
	logic [lbc_pkg::ICON_W-1:0]   chase_pos_q;
	logic [lbc_pkg::ICON_W-1:0]   scan_idx_q;

	// blink store
	logic [NI-1:0]                blink_en_q;
	logic [NI-1:0]                blink_lit_q;
	logic [lbc_pkg::COLOR_W-1:0]  blink_color_q [NI];
	logic [lbc_pkg::PERIOD_W-1:0] blink_half_q  [NI];
	logic [TW-1:0]                blink_last_q  [NI];

	// result staging: a hold slot so the final result can be marked
	logic                         hold_valid_q;
	logic                         hold_wr_q;
	logic [lbc_pkg::ICON_W-1:0]   hold_idx_q;
	logic [lbc_pkg::COLOR_W-1:0]  hold_col_q;
	logic                         hold_rf_q;

	logic                         out_valid_q;
	logic                         out_wr_q;
	logic [lbc_pkg::ICON_W-1:0]   out_idx_q;
	logic [lbc_pkg::COLOR_W-1:0]  out_col_q;
	logic                         out_rf_q;
	logic                         out_last_q;

	logic                           cfg_write;
	logic [lbc_pkg::PERIOD_W-1:0]   interval_next;
	logic [lbc_pkg::CNT_W-1:0]      eff_count;
	logic [lbc_pkg::CNT_W-1:0]      eff_m1;
	logic [lbc_pkg::ITEM_IDX_W-1:0] eff_ext;
	logic [TW-1:0]                  blink_elapsed;
	logic [TW-1:0]                  half_ext;
	logic [TW-1:0]                  chase_elapsed;
	logic [TW-1:0]                  interval_ext;
	logic                           scan_hit;
	logic [lbc_pkg::ICON_W-1:0]     chase_nxt;
	logic                           off_emit;
	logic                           on_emit;
	logic                           pos_in_range;
	logic                           can_push;
	logic                           produce;
	logic                           chase_upd;
	logic                           new_wr;
	logic [lbc_pkg::ICON_W-1:0]     new_idx;
	logic [lbc_pkg::COLOR_W-1:0]    new_col;
	logic                           new_rf;
	logic                           push_out;
	logic                           is_flush;

	assign cfg_write = cfg_valid && cmd.cfg_open;
	assign interval_next = (cfg_index == lbc_pkg::REG_CYCLE_INTERVAL) ?
		cfg_data[lbc_pkg::PERIOD_W-1:0] : cycle_interval_q;

	// count in use, capped
	assign eff_count = (icon_count_q > lbc_pkg::MAX_CNT) ? lbc_pkg::MAX_CNT : icon_count_q;
	assign eff_m1    = eff_count - lbc_pkg::CNT_ONE;
	assign eff_ext   = {{(lbc_pkg::ITEM_IDX_W-lbc_pkg::CNT_W){1'b0}}, eff_count};

	// blink due test for the scanned icon
	assign half_ext      = {{(TW-lbc_pkg::PERIOD_W){1'b0}}, blink_half_q[scan_idx_q]};
	assign blink_elapsed = time_q - blink_last_q[scan_idx_q];
	assign scan_hit      = blink_en_q[scan_idx_q] && (blink_elapsed >= half_ext);

	// chase step decision
	assign interval_ext  = {{(TW-lbc_pkg::PERIOD_W){1'b0}}, cycle_interval_q};
	assign chase_elapsed = time_q - last_chase_q;
	assign chase_nxt = !chase_valid_q ? '0 :
		(({1'b0, chase_pos_q} == eff_m1) ? '0 : chase_pos_q + lbc_pkg::ICON_ONE);
	assign off_emit = chase_valid_q && !blink_en_q[chase_pos_q];
	assign on_emit  = !blink_en_q[chase_nxt];
	assign pos_in_range = ({1'b0, chase_pos_q} < eff_count);

	// room to move the hold slot into the output register
	assign can_push = !out_valid_q || !out_stall;

	always_comb begin
		status.is_tick      = (mode_q == lbc_pkg::MODE_TICK);
		status.cnt_zero     = (eff_count == '0);
		status.cmd_in_range = (idx_q < eff_ext);
		status.scan_hit     = scan_hit;
		status.scan_last    = ({1'b0, scan_idx_q} == eff_m1);
		status.chase_due    = (chase_elapsed >= interval_ext);
		status.chase_two    = off_emit && on_emit;
		status.produce_ok   = !hold_valid_q || can_push;
		status.flush_ok     = can_push;
		status.hold_valid   = hold_valid_q;
	end

	// result produced by this operation
	always_comb begin
		produce   = 1'b0;
		chase_upd = 1'b0;
		new_wr    = 1'b0;
		new_idx   = '0;
		new_col   = '0;
		new_rf    = 1'b0;
		case (cmd.op)
			lbc_pkg::OP_SCAN: begin
				if (scan_hit) begin
					produce = 1'b1;
					new_wr  = 1'b1;
					new_idx = scan_idx_q;
					new_col = blink_lit_q[scan_idx_q] ? '0 : blink_color_q[scan_idx_q];
					new_rf  = 1'b1;
				end
			end
			lbc_pkg::OP_CHASE_FIRST: begin
				produce   = 1'b1;
				chase_upd = !(off_emit && on_emit);
				if (off_emit) begin
					new_wr  = 1'b1;
					new_idx = chase_pos_q;
					new_rf  = !on_emit;
				end else if (on_emit) begin
					new_wr  = 1'b1;
					new_idx = chase_nxt;
					new_col = cycle_color_q;
					new_rf  = 1'b1;
				end else begin
					new_rf  = 1'b1;
				end
			end
			lbc_pkg::OP_CHASE_SECOND: begin
				produce   = 1'b1;
				chase_upd = 1'b1;
				new_wr    = 1'b1;
				new_idx   = chase_nxt;
				new_col   = cycle_color_q;
				new_rf    = 1'b1;
			end
			lbc_pkg::OP_CMD: begin
				produce = 1'b1;
				new_wr  = 1'b1;
				new_idx = idx_q[lbc_pkg::ICON_W-1:0];
				new_col = (mode_q == lbc_pkg::MODE_CLEAR) ? '0 : color_q;
				new_rf  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign is_flush = (cmd.op == lbc_pkg::OP_FLUSH);
	assign push_out = (produce && hold_valid_q) || is_flush;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.op == lbc_pkg::OP_ACCEPT) begin
			mode_q   <= mode;
			idx_q    <= icon_index;
			color_q  <= {red, green, blue};
			period_q <= blink_period;
		end
	end

	// configuration, time, chase and blink flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icon_count_q     <= '0;
			cycle_interval_q <= '0;
			cycle_color_q    <= '0;
			time_q           <= '0;
			last_chase_q     <= '0;
			chase_valid_q    <= 1'b0;
			chase_pos_q      <= '0;
			scan_idx_q       <= '0;
			blink_en_q       <= '0;
			blink_lit_q      <= '0;
		end else begin
			if (cmd.op == lbc_pkg::OP_DECODE) begin
				scan_idx_q <= '0;
				if (mode_q == lbc_pkg::MODE_TICK) begin
					time_q <= time_q + TW'(1);
				end
			end
			if (cmd.op == lbc_pkg::OP_SCAN) begin
				scan_idx_q <= scan_idx_q + lbc_pkg::ICON_ONE;
				if (scan_hit) begin
					blink_lit_q[scan_idx_q] <= !blink_lit_q[scan_idx_q];
				end
			end
			if (chase_upd) begin
				chase_pos_q   <= chase_nxt;
				chase_valid_q <= 1'b1;
				last_chase_q  <= time_q;
			end
			if (cmd.op == lbc_pkg::OP_CMD) begin
				case (mode_q)
					lbc_pkg::MODE_BLINK: begin
						blink_en_q[idx_q[lbc_pkg::ICON_W-1:0]]  <= 1'b1;
						blink_lit_q[idx_q[lbc_pkg::ICON_W-1:0]] <= 1'b1;
					end
					default: begin
						blink_en_q[idx_q[lbc_pkg::ICON_W-1:0]] <= 1'b0;
					end
				endcase
			end
			// a write to a defined register restarts the chase and stops all blinking
			if (cfg_write) begin
				case (cfg_index)
					lbc_pkg::REG_ICON_COUNT:
						icon_count_q <= cfg_data[lbc_pkg::CNT_W-1:0];
					lbc_pkg::REG_CYCLE_INTERVAL:
						cycle_interval_q <= cfg_data[lbc_pkg::PERIOD_W-1:0];
					lbc_pkg::REG_CYCLE_COLOR:
						cycle_color_q <= cfg_data[lbc_pkg::COLOR_W-1:0];
					default: begin
					end
				endcase
				if (cfg_index <= lbc_pkg::REG_CYCLE_COLOR) begin
					last_chase_q  <= time_q - {{(TW-lbc_pkg::PERIOD_W){1'b0}}, interval_next};
					chase_valid_q <= 1'b0;
					chase_pos_q   <= '0;
					blink_en_q    <= '0;
					blink_lit_q   <= '0;
				end
			end
		end
	end

	// blink parameters, written by blink commands and toggles
	always_ff @(posedge clk) begin
		if (cmd.op == lbc_pkg::OP_SCAN && scan_hit) begin
			blink_last_q[scan_idx_q] <= time_q;
		end
		if (cmd.op == lbc_pkg::OP_CMD && mode_q == lbc_pkg::MODE_BLINK) begin
			blink_color_q[idx_q[lbc_pkg::ICON_W-1:0]] <= color_q;
			blink_half_q[idx_q[lbc_pkg::ICON_W-1:0]]  <= period_q;
			blink_last_q[idx_q[lbc_pkg::ICON_W-1:0]]  <= time_q;
		end
	end

	// hold slot and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (produce) begin
				hold_valid_q <= 1'b1;
			end else if (is_flush) begin
				hold_valid_q <= 1'b0;
			end
			if (can_push) begin
				out_valid_q <= push_out;
			end
		end
	end

	// hold slot and output register payload
	always_ff @(posedge clk) begin
		if (produce) begin
			hold_wr_q  <= new_wr;
			hold_idx_q <= new_idx;
			hold_col_q <= new_col;
			hold_rf_q  <= new_rf;
		end
		if (push_out && can_push) begin
			out_wr_q   <= hold_wr_q;
			out_idx_q  <= hold_idx_q;
			out_col_q  <= hold_col_q;
			out_rf_q   <= hold_rf_q;
			out_last_q <= is_flush;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_write = out_wr_q;
	assign pixel_index = out_idx_q;
	assign pixel_color = out_col_q;
	assign refresh     = out_rf_q;
	assign last        = out_last_q;

	`LBC_ASSERT_IMP(a_hold_room, (produce && hold_valid_q), can_push)
	`LBC_ASSERT_IMP(a_chase_pos, chase_valid_q, pos_in_range)
	`LBC_ASSERT_NXT(a_out_held, (out_valid_q && out_stall), (out_valid_q && $stable(out_col_q)))

endmodule

FILE: test/led_icon_blink_and_chase_checker.sv
// Checker for the icon LED blink and chase block: predicts pixel results and compares them.
`timescale 1ns / 1ps
module led_icon_blink_and_chase_checker
	import lbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic [ITEM_IDX_W-1:0] icon_index,
	input  logic [CHAN_W-1:0]     red,
	input  logic [CHAN_W-1:0]     green,
	input  logic [CHAN_W-1:0]     blue,
	input  logic [PERIOD_W-1:0]   blink_period,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  pixel_write,
	input  logic [ICON_W-1:0]     pixel_index,
	input  logic [COLOR_W-1:0]    pixel_color,
	input  logic                  refresh,
	input  logic                  last,
	output int                    fail_count,
	output int                    pixels_pending,
	output int                    requests_seen,
	output int                    pixels_seen
);

	localparam int SHOWN_FAILS = 10;

	typedef struct packed {
		logic               wr;
		logic [ICON_W-1:0]  idx;
		logic [COLOR_W-1:0] rgb;
		logic               rfsh;
		logic               fin;
	} pixel_res_t;

	// register copies
	logic [CNT_W-1:0]    icons_cfg;
	logic [PERIOD_W-1:0] chase_gap;
	logic [COLOR_W-1:0]  chase_rgb;

	// time and chase state
	logic [TIME_W-1:0]   ms_now;
	logic [TIME_W-1:0]   chase_stamp;
	logic                chase_on;
	int unsigned         chase_at;

	// per-icon blink state; colors, periods and stamps stay X until a blink command
	logic [ICON_SLOTS-1:0] blinking;
	logic [ICON_SLOTS-1:0] lit;
	logic [COLOR_W-1:0]    blink_rgb [ICON_SLOTS];
	logic [PERIOD_W-1:0]   half_ms [ICON_SLOTS];
	logic [TIME_W-1:0]     toggled_at [ICON_SLOTS];

	pixel_res_t expected_pixels[$];
	int fails, reqs, pix;

	assign fail_count     = fails;
	assign pixels_pending = expected_pixels.size();
	assign requests_seen  = reqs;
	assign pixels_seen    = pix;

	function automatic pixel_res_t mk_pixel(input logic wr, input int unsigned idx,
		input logic [COLOR_W-1:0] rgb, input logic rfsh);
		pixel_res_t p;
		p.wr   = wr;
		p.idx  = wr ? ICON_W'(idx) : '0;
		p.rgb  = wr ? rgb : '0;
		p.rfsh = rfsh;
		p.fin  = 1'b0;
		return p;
	endfunction

	// a write to a defined register drops the chase and all blinking
	function automatic void restart_chase();
		chase_stamp = ms_now - TIME_W'(chase_gap);
		chase_on    = 1'b0;
		chase_at    = 0;
		blinking    = '0;
		lit         = '0;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ICON_COUNT: begin
				icons_cfg = data[CNT_W-1:0];
				restart_chase();
			end
			REG_CYCLE_INTERVAL: begin
				chase_gap = data[PERIOD_W-1:0];
				restart_chase();
			end
			REG_CYCLE_COLOR: begin
				chase_rgb = data[COLOR_W-1:0];
				restart_chase();
			end
			default: ;
		endcase
	endfunction

	// works out the pixel writes and refreshes one request causes
	function automatic void predict_request(input logic [MODE_W-1:0] m,
		input logic [ITEM_IDX_W-1:0] idx, input logic [COLOR_W-1:0] rgb,
		input logic [PERIOD_W-1:0] per);
		pixel_res_t batch[$];
		pixel_res_t tail;
		int unsigned live;
		int unsigned nxt;
		int unsigned i;
		logic lit_any;
		live = (icons_cfg > MAX_CNT) ? ICON_SLOTS : icons_cfg;
		if (m == MODE_TICK) begin
			ms_now = ms_now + 1'b1;
			if (live != 0) begin
				// blink scan in icon order
				for (i = 0; i < live; i++) begin
					if (blinking[i] && TIME_W'(ms_now - toggled_at[i]) >= TIME_W'(half_ms[i])) begin
						lit[i] = !lit[i];
						toggled_at[i] = ms_now;
						batch.push_back(mk_pixel(1'b1, i, lit[i] ? blink_rgb[i] : '0, 1'b1));
					end
				end
				// chase step, skipping blinking icons
				if (TIME_W'(ms_now - chase_stamp) >= TIME_W'(chase_gap)) begin
					nxt = chase_on ? (chase_at + 1) % live : 0;
					lit_any = 1'b0;
					if (chase_on && chase_at < live && !blinking[chase_at])
						batch.push_back(mk_pixel(1'b1, chase_at, '0, 1'b0));
					if (!blinking[nxt]) begin
						batch.push_back(mk_pixel(1'b1, nxt, chase_rgb, 1'b1));
						lit_any = 1'b1;
					end
					if (!lit_any) begin
						if (batch.size() > 0 && !batch[batch.size()-1].rfsh) begin
							tail = batch.pop_back();
							tail.rfsh = 1'b1;
							batch.push_back(tail);
						end else begin
							batch.push_back(mk_pixel(1'b0, 0, '0, 1'b1));
						end
					end
					chase_at    = nxt;
					chase_on    = 1'b1;
					chase_stamp = ms_now;
				end
			end
		end else if (idx < live) begin
			case (m)
				MODE_SET: begin
					blinking[idx] = 1'b0;
					batch.push_back(mk_pixel(1'b1, idx, rgb, 1'b1));
				end
				MODE_BLINK: begin
					blinking[idx]   = 1'b1;
					blink_rgb[idx]  = rgb;
					half_ms[idx]    = per;
					toggled_at[idx] = ms_now;
					lit[idx]        = 1'b1;
					batch.push_back(mk_pixel(1'b1, idx, rgb, 1'b1));
				end
				default: begin
					blinking[idx] = 1'b0;
					batch.push_back(mk_pixel(1'b1, idx, '0, 1'b1));
				end
			endcase
		end
		if (batch.size() > 0) begin
			tail = batch.pop_back();
			tail.fin = 1'b1;
			batch.push_back(tail);
		end
		foreach (batch[k])
			expected_pixels.push_back(batch[k]);
	endfunction

	function automatic void check_pixel();
		pixel_res_t got, want;
		string bad;
		got.wr   = pixel_write;
		got.idx  = pixel_index;
		got.rgb  = pixel_color;
		got.rfsh = refresh;
		got.fin  = last;
		pix++;
		if (expected_pixels.size() == 0) begin
			fails++;
			if (fails <= SHOWN_FAILS) begin
				$write("[%0t] result with nothing pending:", $realtime);
				$display(" wr=%0b idx=%0d rgb=%06h rf=%0b last=%0b",
					got.wr, got.idx, got.rgb, got.rfsh, got.fin);
			end
			return;
		end
		want = expected_pixels.pop_front();
		bad = "";
		if (got.wr !== want.wr)     bad = {bad, " pixel_write"};
		if (got.idx !== want.idx)   bad = {bad, " pixel_index"};
		if (got.rgb !== want.rgb)   bad = {bad, " pixel_color"};
		if (got.rfsh !== want.rfsh) bad = {bad, " refresh"};
		if (got.fin !== want.fin)   bad = {bad, " last"};
		if (bad != "") begin
			fails++;
			if (fails <= SHOWN_FAILS) begin
				$write("[%0t] bad%s: want wr=%0b idx=%0d rgb=%06h rf=%0b last=%0b,",
					$realtime, bad, want.wr, want.idx, want.rgb, want.rfsh, want.fin);
				$display(" got wr=%0b idx=%0d rgb=%06h rf=%0b last=%0b",
					got.wr, got.idx, got.rgb, got.rfsh, got.fin);
			end
		end
	endfunction

	// results first, since they come from earlier requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icons_cfg = '0;
			chase_gap = '0;
			chase_rgb = '0;
			ms_now    = '0;
			restart_chase();
			expected_pixels.delete();
			fails = 0;
			reqs  = 0;
			pix   = 0;
		end else begin
			if (out_valid && !out_stall)
				check_pixel();
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				reqs++;
				predict_request(mode, icon_index, {red, green, blue}, blink_period);
			end
		end
	end

endmodule

FILE: test/led_icon_blink_and_chase_top_tb.sv
// Stimulus and verdict for the icon LED blink and chase block.
`timescale 1ns / 1ps
module led_icon_blink_and_chase_top_tb;
	import lbc_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RST_CYCLES  = 11;
	localparam int SETTLE      = 24;
	localparam int CYCLE_LIMIT = 300000;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [MODE_W-1:0]     mode = MODE_TICK;
	logic [ITEM_IDX_W-1:0] icon_index = '0;
	logic [CHAN_W-1:0]     red = '0;
	logic [CHAN_W-1:0]     green = '0;
	logic [CHAN_W-1:0]     blue = '0;
	logic [PERIOD_W-1:0]   blink_period = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  pixel_write;
	logic [ICON_W-1:0]     pixel_index;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  refresh;
	logic                  last;

	int fail_count, pixels_pending, requests_seen, pixels_seen;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int reg_writes = 0;
	int cycles = 0;

	led_icon_blink_and_chase_top dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .mode, .icon_index, .red, .green, .blue, .blink_period,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.out_valid, .out_stall, .pixel_write, .pixel_index, .pixel_color, .refresh, .last
	);

	led_icon_blink_and_chase_checker chk (
		.clk, .arst_n,
		.in_valid, .in_stall, .mode, .icon_index, .red, .green, .blue, .blink_period,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.out_valid, .out_stall, .pixel_write, .pixel_index, .pixel_color, .refresh, .last,
		.fail_count, .pixels_pending, .requests_seen, .pixels_seen
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles, %0d results pending",
				cycles, pixels_pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// one request; returns at the edge where it is taken
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [ITEM_IDX_W-1:0] idx,
		input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
		input logic [PERIOD_W-1:0] per);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		icon_index   <= idx;
		red          <= r;
		green        <= g;
		blue         <= b;
		blink_period <= per;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending, let every pixel result drain, then give a tick with no result time to finish
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixels_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_registers(input logic [CFG_DATA_W-1:0] cnt,
		input logic [CFG_DATA_W-1:0] gap, input logic [CFG_DATA_W-1:0] rgb);
		put_register(REG_ICON_COUNT, cnt);
		put_register(REG_CYCLE_INTERVAL, gap);
		put_register(REG_CYCLE_COLOR, rgb);
	endtask

	// mostly in-range commands and ticks, some stray indexes and long periods
	task automatic random_items(input int n, input int live);
		int unsigned pick;
		logic [MODE_W-1:0] m;
		logic [ITEM_IDX_W-1:0] idx;
		logic [PERIOD_W-1:0] per;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 45)      m = MODE_TICK;
			else if (pick < 62) m = MODE_SET;
			else if (pick < 85) m = MODE_BLINK;
			else                m = MODE_CLEAR;
			if ($urandom_range(9) == 0)
				idx = ITEM_IDX_W'($urandom_range(255));
			else
				idx = ITEM_IDX_W'($urandom_range(live - 1));
			if ($urandom_range(7) == 0)
				per = PERIOD_W'($urandom);
			else
				per = PERIOD_W'($urandom_range(6));
			send_item(m, idx, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), per);
		end
	endtask

	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 9;
		stall_pct     = 55;

		// no icons: time moves, nothing comes out
		send_item(MODE_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(MODE_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		quiesce();

		// all eight icons, chase on every tick in full white
		set_registers(CFG_DATA_W'(ICON_SLOTS), '0, 24'hFFFFFF);
		send_item(MODE_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(MODE_SET, 8'd7, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
		send_item(MODE_BLINK, 8'd1, 8'hAB, 8'hCD, 8'hEF, 16'h0000);
		send_item(MODE_BLINK, 8'd2, 8'h12, 8'h34, 8'h56, 16'd3);
		// chase turns off icon 0 and lands on blinking icon 1
		send_item(MODE_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
		// chase moves between two blinking icons: refresh only
		send_item(MODE_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(MODE_BLINK, 8'd3, 8'h00, 8'h00, 8'h00, 16'hFFFF);
		send_item(MODE_CLEAR, 8'd1, 8'h00, 8'h00, 8'h00, 16'h0000);
		// indexes past the count are dropped
		send_item(MODE_SET, 8'd255, 8'h55, 8'hAA, 8'h55, 16'h0000);
		send_item(MODE_BLINK, 8'd8, 8'hAA, 8'h55, 8'hAA, 16'h0001);
		send_item(MODE_CLEAR, 8'h80, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(MODE_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(MODE_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(MODE_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(MODE_SET, 8'd0, 8'hFF, 8'h00, 8'h00, 16'hFFFF);
		send_item(MODE_CLEAR, 8'd7, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
		send_item(MODE_BLINK, 8'd5, 8'hFF, 8'hFF, 8'hFF, 16'd1);
		send_item(MODE_TICK, 8'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(MODE_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
		quiesce();

		// sender mostly busy, receiver often stalled
		set_registers({20'($urandom), 4'd5}, 24'd3, 24'($urandom));
		random_items(25, 5);
		quiesce();
		random_items(20, 5);
		quiesce();

		// sender often idle, receiver mostly ready; count above the cap, longest interval
		send_idle_pct = 55;
		stall_pct     = 9;
		set_registers({20'($urandom), 4'hF}, 24'hFFFF, 24'h000000);
		put_register(REG_SPARE, 24'($urandom));
		random_items(50, ICON_SLOTS);
		quiesce();

		// no idling on either side
		send_idle_pct = 0;
		stall_pct     = 0;
		set_registers(24'd1, 24'd1, 24'($urandom));
		random_items(20, 1);
		quiesce();
		set_registers(CFG_DATA_W'(ICON_SLOTS), 24'd0, 24'($urandom));
		random_items(25, ICON_SLOTS);
		quiesce();

		$display("covered %0d requests and %0d pixel results over %0d register writes",
			requests_seen, pixels_seen, reg_writes);
		$display("icon counts 0, 1, 5, 8 and 15; chase intervals 0 to 65535; three idle patterns");
		if (fail_count == 0 && pixels_pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d failures, %0d results never arrived", fail_count, pixels_pending);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
